[src/rtbb_pkg.sv]
// Shared types and constants for the RGBA 2x2 box downsampler.
package rtbb_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;
    localparam int PAIR_W      = CHAN_W + 1;
    localparam int LINE_W      = NUM_CHAN * PAIR_W;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int DEF_MAX_WIDTH = 4096;
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4096);

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_pixel;
    typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] t_pair_sums;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

endpackage

[src/rtbb_line_store.sv]
// Line store holding the even-row pair sums, one write and one registered read port.
module rtbb_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 36
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rtbb_lane.sv]
// One color channel lane: horizontal pair sum and the 2x2 truncated average.
module rtbb_lane import rtbb_pkg::*; (
    input  logic              i_clk,
    input  logic [CHAN_W-1:0] i_left,
    input  logic [CHAN_W-1:0] i_pixel,
    input  logic              i_load,
    input  logic [PAIR_W-1:0] i_stored,
    output logic [PAIR_W-1:0] o_pair_sum,
    output logic [CHAN_W-1:0] o_average
);

    logic [PAIR_W-1:0] r_pair;
    logic [PAIR_W-1:0] n_pair;
    logic [PAIR_W:0]   block_sum;

    assign n_pair     = PAIR_W'(i_left) + PAIR_W'(i_pixel);
    assign o_pair_sum = n_pair;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pair <= n_pair;
        end
    end

    assign block_sum = (PAIR_W + 1)'(r_pair) + (PAIR_W + 1)'(i_stored);
    assign o_average = block_sum[PAIR_W:2];

endmodule

[src/rgba_two_by_two_box_downsampler.sv]
// Top level of the RGBA8 2x2 box downsampler with line store and output register.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_red_in, i_green_in, i_blue_in, i_alpha_in
//  output   | o_out_valid / i_out_ready  | o_red_out .. o_alpha_out, o_last_pixel
//  config   | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One source pixel is taken every cycle unless both result stages are stalled. A
// result moves from the pixel completing its block through the line store read
// stage and the lane adders into the output register. Reset clears the counters
// and handshake state; the line store is not cleared. A stalled output holds one
// result in the output register and one in the read stage before input stops.
module rgba_two_by_two_box_downsampler import rtbb_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CHAN_W-1:0]    i_red_in,
    input  logic [CHAN_W-1:0]    i_green_in,
    input  logic [CHAN_W-1:0]    i_blue_in,
    input  logic [CHAN_W-1:0]    i_alpha_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAN_W-1:0]    o_red_out,
    output logic [CHAN_W-1:0]    o_green_out,
    output logic [CHAN_W-1:0]    o_blue_out,
    output logic [CHAN_W-1:0]    o_alpha_out,
    output logic                 o_last_pixel,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0] r_img_w;
    logic [CFG_W-1:0] r_img_h;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    t_pixel           r_left;

    logic             r_s1_valid;
    logic             r_s1_last;
    logic             r_out_valid;
    logic             r_out_last;
    t_pixel           r_out_pix;

    logic [WW-1:0]    eff_w;
    logic [CFG_W-1:0] eff_h;
    logic [WW-1:0]    half_w;
    logic [CFG_W-1:0] used_h;
    logic [CW-1:0]    pair;
    logic             col_last;
    logic             row_last;
    logic             in_range;
    logic             blk_last;
    logic             accept;
    logic             s1_adv;
    logic             mem_we;
    logic             mem_re;
    t_pixel           pix_in;
    t_pair_sums       pair_sums;
    t_pair_sums       stored;
    t_pixel           averages;

    always_comb begin
        if (r_img_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_img_w);
        end
        if (r_img_h == '0) begin
            eff_h = CFG_W'(1);
        end else if (32'(r_img_h) > MAX_HEIGHT) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_img_h;
        end
    end

    assign half_w   = eff_w >> 1;
    assign used_h   = {eff_h[CFG_W-1:1], 1'b0};
    assign pair     = r_col >> 1;
    assign col_last = (WW'(r_col) + WW'(1)) >= eff_w;
    assign row_last = (CFG_W'(r_row) + CFG_W'(1)) >= eff_h;
    assign in_range = r_col[0] && (WW'(pair) < half_w) && (CFG_W'(r_row) < used_h);
    assign blk_last = ((WW'(pair) + WW'(1)) == half_w)
                   && ((CFG_W'(r_row) + CFG_W'(1)) == used_h);

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_s1_valid || s1_adv);
    assign accept     = i_in_valid && o_in_ready;
    assign mem_we     = accept && in_range && !r_row[0];
    assign mem_re     = accept && in_range && r_row[0];

    assign pix_in = {i_alpha_in, i_blue_in, i_green_in, i_red_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= SIZE_RESET;
            r_img_h <= SIZE_RESET;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_img_w <= i_cfg_data;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_img_h <= i_cfg_data;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_col[0]) begin
            r_left <= pix_in;
        end
    end

    rtbb_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (LINE_W)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (pair[AW-1:0]),
        .i_wdata (pair_sums),
        .i_re    (mem_re),
        .i_raddr (pair[AW-1:0]),
        .o_rdata (stored)
    );

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        rtbb_lane u_lane (
            .i_clk      (i_clk),
            .i_left     (r_left[g]),
            .i_pixel    (pix_in[g]),
            .i_load     (mem_re),
            .i_stored   (stored[g]),
            .o_pair_sum (pair_sums[g]),
            .o_average  (averages[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mem_re) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_s1_last <= blk_last;
        end
        if (s1_adv) begin
            r_out_pix  <= averages;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_out    = r_out_pix[0];
    assign o_green_out  = r_out_pix[1];
    assign o_blue_out   = r_out_pix[2];
    assign o_alpha_out  = r_out_pix[3];
    assign o_last_pixel = r_out_last;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < eff_w)
        else $error("column counter beyond image width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CFG_W'(r_row) < eff_h)
        else $error("row counter beyond image height");

    a_read_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> r_s1_valid)
        else $error("block completing item did not reach the read stage");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both result stages are stalled");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the RGBA 2x2 box downsampler.
module testbench import rtbb_pkg::*;;

    localparam int  LINE_PAIRS     = DEF_MAX_WIDTH / 2;
    localparam int  DRAIN_CYCLES   = 6;
    localparam int  STALL_LIMIT    = 3000;
    localparam int  PHASE_ITEMS    = 320;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        t_pixel avg;
        logic   is_last;
    } t_block_avg;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CHAN_W-1:0]    i_red_in = '0;
    logic [CHAN_W-1:0]    i_green_in = '0;
    logic [CHAN_W-1:0]    i_blue_in = '0;
    logic [CHAN_W-1:0]    i_alpha_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CHAN_W-1:0]    o_red_out;
    logic [CHAN_W-1:0]    o_green_out;
    logic [CHAN_W-1:0]    o_blue_out;
    logic [CHAN_W-1:0]    o_alpha_out;
    logic                 o_last_pixel;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int send_idle_pct = 22;
    int recv_idle_pct = 63;
    int fail_count = 0;
    int stall_cycles = 0;

    t_block_avg       pending_averages[$];
    t_pair_sums       even_row_sums[LINE_PAIRS];
    t_pixel           left_pixel;
    int               col_pos;
    int               row_pos;
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;

    string chan_name[NUM_CHAN] = '{"red_out", "green_out", "blue_out", "alpha_out"};

    rgba_two_by_two_box_downsampler u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_alpha_in   (i_alpha_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out),
        .o_last_pixel (o_last_pixel),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_width();
        if (cfg_width == '0) return 1;
        if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int eff_height();
        if (cfg_height == '0) return 1;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(cfg_height);
    endfunction

    task automatic box_filter_pixel(input t_pixel px);
        int               w;
        int               used_h;
        int               pair;
        t_pair_sums       sums;
        t_block_avg       res;
        logic [PAIR_W:0]  total;
        w      = eff_width();
        used_h = eff_height() & ~1;
        pair   = col_pos / 2;
        if (col_pos % 2 == 0) begin
            left_pixel = px;
        end else if (pair < w / 2 && row_pos < used_h) begin
            if (row_pos % 2 == 0) begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    sums[c] = PAIR_W'(left_pixel[c]) + PAIR_W'(px[c]);
                end
                even_row_sums[pair] = sums;
            end else begin
                sums = even_row_sums[pair];
                for (int c = 0; c < NUM_CHAN; c++) begin
                    total = sums[c] + left_pixel[c] + px[c];
                    res.avg[c] = total[PAIR_W:2];
                end
                res.is_last = (pair + 1 == w / 2) && (row_pos + 1 == used_h);
                pending_averages.push_back(res);
            end
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= eff_height()) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    function automatic logic [CHAN_W-1:0] rand_byte();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    function automatic t_pixel make_pixel(input logic [CHAN_W-1:0] r, g, b, a);
        return {a, b, g, r};
    endfunction

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red_in   <= px[0];
        i_green_in <= px[1];
        i_blue_in  <= px[2];
        i_alpha_in <= px[3];
        do @(posedge i_clk); while (!o_in_ready);
        box_filter_pixel(px);
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++) begin
            send_pixel(make_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte()));
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT) begin
            if (idx == CFG_IMAGE_WIDTH) cfg_width = val;
            else cfg_height = val;
            col_pos = 0;
            row_pos = 0;
        end
        @(posedge i_clk);
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
    endtask

    task automatic test_reset_size();
        send_random_pixels(32);
        wait_idle();
    endtask

    task automatic test_extremes();
        set_size(2, 2);
        repeat (4) send_pixel(make_pixel('1, '1, '1, '1));
        repeat (4) send_pixel(make_pixel('0, '0, '0, '0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd254, 8'd1, 8'd0, 8'd255));
        wait_idle();
        set_size(3, 3);
        send_random_pixels(9);
        wait_idle();
    endtask

    task automatic test_degenerate_sizes();
        set_size(1, 4);
        send_random_pixels(8);
        wait_idle();
        set_size(4, 1);
        send_random_pixels(8);
        wait_idle();
        set_size(0, 0);
        send_random_pixels(4);
        wait_idle();
    endtask

    task automatic test_register_restart();
        set_size(4, 4);
        send_random_pixels(6);
        wait_idle();
        write_reg(CFG_SPARE_LO, CFG_W'($urandom_range(8191)));
        write_reg(CFG_SPARE_HI, CFG_W'($urandom_range(8191)));
        send_random_pixels(10);
        send_random_pixels(5);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(4));
        send_random_pixels(16);
        wait_idle();
    endtask

    task automatic test_width_clamp();
        set_size(8191, 2);
        send_random_pixels(32);
        wait_idle();
    endtask

    task automatic test_height_clamp();
        set_size(2, 8191);
        send_random_pixels(32);
        wait_idle();
    endtask

    task automatic test_random_frames(input int target);
        int sent;
        int w;
        int h;
        int n;
        sent = 0;
        while (sent < target) begin
            case ($urandom_range(9))
                0: w = $urandom_range(1);
                1: w = $urandom_range(17, 40);
                default: w = $urandom_range(2, 12);
            endcase
            h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 9);
            set_size(w, h);
            if ($urandom_range(7) == 0) begin
                write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          CFG_W'($urandom_range(8191)));
            end
            n = eff_width() * eff_height();
            if ($urandom_range(4) == 0) n = $urandom_range(1, n);
            else n = n * $urandom_range(1, 2);
            if (n > target - sent) n = target - sent;
            send_random_pixels(n);
            wait_idle();
            if (eff_width() > 1 && eff_height() > 1) sent += n;
        end
    endtask

    always @(posedge i_clk) begin
        t_block_avg want;
        t_pixel     got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_alpha_out, o_blue_out, o_green_out, o_red_out};
            if (pending_averages.size() == 0) begin
                $error("Unexpected result item with no expected item waiting.");
                fail_count++;
            end else begin
                want = pending_averages.pop_front();
                for (int c = 0; c < NUM_CHAN; c++) begin
                    if (got[c] !== want.avg[c]) begin
                        $error("%s: expected %0d, actual %0d", chan_name[c], want.avg[c],
                               got[c]);
                        fail_count++;
                    end
                end
                if (o_last_pixel !== want.is_last) begin
                    $error("last_pixel: expected %0d, actual %0d", want.is_last, o_last_pixel);
                    fail_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        cfg_width  = SIZE_RESET;
        cfg_height = SIZE_RESET;
        col_pos    = 0;
        row_pos    = 0;
        left_pixel = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_extremes();
        test_degenerate_sizes();
        test_register_restart();
        test_width_clamp();
        test_height_clamp();
        test_random_frames(PHASE_ITEMS);

        send_idle_pct = 63;
        recv_idle_pct = 22;
        test_random_frames(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(PHASE_ITEMS);

        wait_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
